### src/sfr_pkg.sv
// Shared types, codes and the CRC-16 byte update for the serial frame receiver.
package sfr_pkg;

  typedef logic [1:0] action_t;
  localparam action_t ACT_RX      = 2'd0;
  localparam action_t ACT_READ    = 2'd1;
  localparam action_t ACT_RELEASE = 2'd2;

  typedef logic [2:0] reg_index_t;
  localparam reg_index_t REG_HEADER_FIRST   = 3'd0;
  localparam reg_index_t REG_HEADER_SECOND  = 3'd1;
  localparam reg_index_t REG_TRAILER_FIRST  = 3'd2;
  localparam reg_index_t REG_TRAILER_SECOND = 3'd3;
  localparam reg_index_t REG_CHECK_ENABLE   = 3'd4;
  localparam reg_index_t REG_CRC_POLYNOMIAL = 3'd5;
  localparam reg_index_t REG_CRC_START      = 3'd6;

  localparam logic [7:0]  HEADER_FIRST_RST   = 8'hAA;
  localparam logic [7:0]  HEADER_SECOND_RST  = 8'h55;
  localparam logic [7:0]  TRAILER_FIRST_RST  = 8'h0D;
  localparam logic [7:0]  TRAILER_SECOND_RST = 8'h0A;
  localparam logic        CHECK_ENABLE_RST   = 1'b1;
  localparam logic [15:0] CRC_POLYNOMIAL_RST = 16'hA001;
  localparam logic [15:0] CRC_START_RST      = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  trailer_first;
    logic [7:0]  trailer_second;
    logic        check_enable;
    logic [15:0] crc_polynomial;
    logic [15:0] crc_start;
  } sfr_cfg_t;

  typedef struct packed {
    logic       frame_ready;
    logic       frame_accepted;
    logic       crc_mismatch;
    logic       framing_error;
    logic [7:0] held_id;
    logic [6:0] held_length;
  } sfr_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sfr_parse.sv
// Frame parser: header, id, length, payload store writes, CRC-16 and trailer checks.
module sfr_parse #(
  parameter int CAPACITY = 64,
  parameter int ADDR_W   = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  sfr_pkg::action_t    action,
  input  logic [7:0]          rx_byte,
  input  sfr_pkg::sfr_cfg_t   cfg,
  output logic                mem_we,
  output logic [ADDR_W-1:0]   mem_waddr,
  output logic [7:0]          mem_wdata,
  output sfr_pkg::sfr_status_t status
);
  import sfr_pkg::*;

  typedef enum logic [3:0] {
    PH_HEAD1, PH_HEAD2, PH_ID, PH_LEN, PH_DATA, PH_CRCL, PH_CRCH, PH_END1, PH_END2
  } phase_t;

  localparam logic [7:0] CAP8 = 8'(CAPACITY);

  phase_t      phase, phase_next;
  logic [6:0]  wpos, wpos_next;
  logic [7:0]  ident, ident_next;
  logic [7:0]  size, size_next;
  logic [15:0] rx_crc, rx_crc_next;
  logic [15:0] run_crc, run_crc_next;
  logic        ready, ready_next;
  logic        accepted, mismatch, ferr;

  always_comb begin
    phase_next   = phase;
    wpos_next    = wpos;
    ident_next   = ident;
    size_next    = size;
    rx_crc_next  = rx_crc;
    run_crc_next = run_crc;
    ready_next   = ready;
    accepted     = 1'b0;
    mismatch     = 1'b0;
    ferr         = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = ADDR_W'(wpos);
    mem_wdata    = rx_byte;
    if (take) begin
      if (action == ACT_RX && !ready) begin
        case (phase)
          PH_HEAD1: begin
            if (rx_byte == cfg.header_first) phase_next = PH_HEAD2;
          end
          PH_HEAD2: begin
            phase_next = (rx_byte == cfg.header_second) ? PH_ID : PH_HEAD1;
          end
          PH_ID: begin
            ident_next = rx_byte;
            phase_next = PH_LEN;
          end
          PH_LEN: begin
            size_next    = rx_byte;
            wpos_next    = 7'd0;
            run_crc_next = cfg.crc_start;
            if (rx_byte > CAP8) begin
              ferr       = 1'b1;
              phase_next = PH_HEAD1;
            end else if (rx_byte == 8'd0) begin
              phase_next = PH_CRCL;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            mem_we       = ({1'b0, wpos} < CAP8);
            wpos_next    = wpos + 7'd1;
            run_crc_next = crc_byte(run_crc, rx_byte, cfg.crc_polynomial);
            if ({1'b0, wpos_next} >= size) phase_next = PH_CRCL;
          end
          PH_CRCL: begin
            rx_crc_next = {rx_crc[15:8], rx_byte};
            phase_next  = PH_CRCH;
          end
          PH_CRCH: begin
            rx_crc_next = {rx_byte, rx_crc[7:0]};
            phase_next  = PH_END1;
          end
          PH_END1: begin
            if (rx_byte == cfg.trailer_first) begin
              phase_next = PH_END2;
            end else begin
              ferr       = 1'b1;
              phase_next = PH_HEAD1;
            end
          end
          PH_END2: begin
            phase_next = PH_HEAD1;
            if (rx_byte != cfg.trailer_second) begin
              ferr = 1'b1;
            end else if (cfg.check_enable && run_crc != rx_crc) begin
              mismatch = 1'b1;
            end else begin
              accepted   = 1'b1;
              ready_next = 1'b1;
            end
          end
          default: begin
            phase_next = PH_HEAD1;
          end
        endcase
      end else if (action == ACT_RELEASE) begin
        ready_next = 1'b0;
      end
    end
    status.frame_ready    = ready_next;
    status.frame_accepted = accepted;
    status.crc_mismatch   = mismatch;
    status.framing_error  = ferr;
    status.held_id        = ready_next ? ident_next : 8'd0;
    status.held_length    = ready_next ? size_next[6:0] : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEAD1;
      wpos    <= 7'd0;
      ident   <= 8'd0;
      size    <= 8'd0;
      rx_crc  <= 16'd0;
      run_crc <= CRC_START_RST;
      ready   <= 1'b0;
    end else begin
      phase   <= phase_next;
      wpos    <= wpos_next;
      ident   <= ident_next;
      size    <= size_next;
      rx_crc  <= rx_crc_next;
      run_crc <= run_crc_next;
      ready   <= ready_next;
    end
  end

endmodule

### src/serial_frame_receiver_crc16.sv
// Serial frame receiver with CRC-16 check: top level with stream ports and config registers.
// The result of an item is registered and presented on the output in the cycle after its transaction.
// Throughput: one item per cycle while the output is not stalled; the payload RAM has one write and one read port.
// A stalled output holds its result and blocks input only while the result register is full.
// Reset clears parser state, flags and config registers to their defaults; the payload
// store is not cleared.
module serial_frame_receiver_crc16 #(
  parameter int PAYLOAD_CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [15:0]             s_tdata,   // rx_byte[7:0], read_index[13:8], zero[15:14]
  input  sfr_pkg::action_t        s_tuser,   // action[1:0]
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [31:0]             m_tdata,   // frame_ready[0], frame_accepted[1],
                                             // crc_mismatch[2], framing_error[3],
                                             // held_id[11:4], held_length[18:12],
                                             // read_data[26:19], zero[31:27]
  input  logic                    cfg_we,
  input  sfr_pkg::reg_index_t     cfg_addr,
  input  logic [15:0]             cfg_wdata
);
  import sfr_pkg::*;

  localparam int         ADDR_W = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;
  localparam logic [7:0] CAP8   = 8'(PAYLOAD_CAPACITY);

  sfr_cfg_t    cfg;
  sfr_status_t status, st_q;
  logic        take;
  logic        out_valid;
  logic        rd_ok, rd_ok_q;
  logic [5:0]  read_index;
  logic [7:0]  rx_byte;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]  mem_wdata;
  logic [7:0]  mem_rdata;
  logic [7:0]  read_data;

  assign rx_byte    = s_tdata[7:0];
  assign read_index = s_tdata[13:8];
  assign s_tready   = !out_valid || m_tready;
  assign take       = s_tvalid && s_tready;
  assign rd_ok      = (s_tuser == ACT_READ) && ({2'b00, read_index} < CAP8);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first   <= HEADER_FIRST_RST;
      cfg.header_second  <= HEADER_SECOND_RST;
      cfg.trailer_first  <= TRAILER_FIRST_RST;
      cfg.trailer_second <= TRAILER_SECOND_RST;
      cfg.check_enable   <= CHECK_ENABLE_RST;
      cfg.crc_polynomial <= CRC_POLYNOMIAL_RST;
      cfg.crc_start      <= CRC_START_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HEADER_FIRST:   cfg.header_first   <= cfg_wdata[7:0];
        REG_HEADER_SECOND:  cfg.header_second  <= cfg_wdata[7:0];
        REG_TRAILER_FIRST:  cfg.trailer_first  <= cfg_wdata[7:0];
        REG_TRAILER_SECOND: cfg.trailer_second <= cfg_wdata[7:0];
        REG_CHECK_ENABLE:   cfg.check_enable   <= cfg_wdata[0];
        REG_CRC_POLYNOMIAL: cfg.crc_polynomial <= cfg_wdata;
        REG_CRC_START:      cfg.crc_start      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sfr_parse #(
    .CAPACITY (PAYLOAD_CAPACITY),
    .ADDR_W   (ADDR_W)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .action    (s_tuser),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .status    (status)
  );

  sfr_ram #(
    .WIDTH  (8),
    .DEPTH  (PAYLOAD_CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (take && rd_ok),
    .raddr (ADDR_W'(read_index)),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      st_q    <= status;
      rd_ok_q <= rd_ok;
    end
  end

  assign read_data = rd_ok_q ? mem_rdata : 8'd0;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {5'd0, read_data, st_q.held_length, st_q.held_id, st_q.framing_error,
                      st_q.crc_mismatch, st_q.frame_accepted, st_q.frame_ready};

endmodule

### tb/tb.sv
// Testbench for serial_frame_receiver_crc16: a directed table, then random frame traffic.
`timescale 1ns / 1ps

module tb;
  import sfr_pkg::*;

  localparam int PAYLOAD_CAP = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam action_t ACT_UNDEFINED = 2'd3;

  typedef enum logic [3:0] {
    P_HEAD1, P_HEAD2, P_ID, P_LEN, P_DATA, P_CRC_LO, P_CRC_HI, P_TRL1, P_TRL2
  } parse_phase_t;

  typedef struct packed {
    logic       frame_ready;
    logic       frame_accepted;
    logic       crc_mismatch;
    logic       framing_error;
    logic [7:0] held_id;
    logic [6:0] held_length;
    logic [7:0] read_data;
  } rx_status_t;

  typedef enum logic [1:0] {BYTE_LIT, BYTE_CRC_LO, BYTE_CRC_HI_BAD} byte_src_t;

  typedef struct {
    action_t    act;
    logic [7:0] data;
    logic [5:0] idx;
    byte_src_t  src;
    bit         typed;
    rx_status_t want;
  } stim_row_t;

  localparam rx_status_t ST_IDLE     = '0;
  localparam rx_status_t ST_FRAMING  = '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 7'd0, 8'h00};
  localparam rx_status_t ST_CRC_BAD  = '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 7'd0, 8'h00};
  localparam rx_status_t ST_ACCEPTED = '{1'b1, 1'b1, 1'b0, 1'b0, 8'hFF, 7'd0, 8'h00};
  localparam rx_status_t ST_HELD     = '{1'b1, 1'b0, 1'b0, 1'b0, 8'hFF, 7'd0, 8'h00};
  localparam rx_status_t ST_HELD_FF  = '{1'b1, 1'b0, 1'b0, 1'b0, 8'hFF, 7'd0, 8'hFF};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  action_t     s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_we;
  reg_index_t  cfg_addr;
  logic [15:0] cfg_wdata;

  sfr_cfg_t     cfg;
  parse_phase_t phase;
  logic [7:0]   payload [PAYLOAD_CAP];
  bit           stored [PAYLOAD_CAP];
  bit           any_stored;
  logic [6:0]   wr_pos;
  logic [7:0]   hold_ident;
  logic [7:0]   frame_len;
  logic [15:0]  crc_rx;
  logic [15:0]  crc_acc;
  logic         held;

  rx_status_t status_due [$];
  rx_status_t got_want;
  stim_row_t  plan [$];
  int         fails;
  int         cycles;
  int         items_done;
  int         send_gap_pct;
  int         ready_stall_pct;

  serial_frame_receiver_crc16 u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ cfg.crc_polynomial) : (r >> 1);
    return r;
  endfunction

  function automatic rx_status_t deframe_step(action_t act, logic [7:0] b, logic [5:0] ridx);
    rx_status_t s;
    s = ST_IDLE;
    if (act == ACT_RX && !held) begin
      case (phase)
        P_HEAD1: if (b == cfg.header_first) phase = P_HEAD2;
        P_HEAD2: phase = (b == cfg.header_second) ? P_ID : P_HEAD1;
        P_ID: begin
          hold_ident = b;
          phase = P_LEN;
        end
        P_LEN: begin
          frame_len = b;
          wr_pos = '0;
          crc_acc = cfg.crc_start;
          if (b > PAYLOAD_CAP) begin
            s.framing_error = 1'b1;
            phase = P_HEAD1;
          end else if (b == 8'd0) begin
            phase = P_CRC_LO;
          end else begin
            phase = P_DATA;
          end
        end
        P_DATA: begin
          if (wr_pos < PAYLOAD_CAP) begin
            payload[wr_pos[5:0]] = b;
            stored[wr_pos[5:0]] = 1'b1;
            any_stored = 1'b1;
          end
          wr_pos = wr_pos + 7'd1;
          crc_acc = crc16_update(crc_acc, b);
          if ({1'b0, wr_pos} >= frame_len) phase = P_CRC_LO;
        end
        P_CRC_LO: begin
          crc_rx[7:0] = b;
          phase = P_CRC_HI;
        end
        P_CRC_HI: begin
          crc_rx[15:8] = b;
          phase = P_TRL1;
        end
        P_TRL1: begin
          if (b == cfg.trailer_first) begin
            phase = P_TRL2;
          end else begin
            s.framing_error = 1'b1;
            phase = P_HEAD1;
          end
        end
        P_TRL2: begin
          phase = P_HEAD1;
          if (b != cfg.trailer_second) begin
            s.framing_error = 1'b1;
          end else if (cfg.check_enable && crc_acc != crc_rx) begin
            s.crc_mismatch = 1'b1;
          end else begin
            s.frame_accepted = 1'b1;
            held = 1'b1;
          end
        end
        default: phase = P_HEAD1;
      endcase
    end else if (act == ACT_READ) begin
      s.read_data = payload[ridx];
    end else if (act == ACT_RELEASE) begin
      held = 1'b0;
    end
    s.frame_ready = held;
    s.held_id = held ? hold_ident : 8'h00;
    s.held_length = held ? frame_len[6:0] : 7'd0;
    return s;
  endfunction

  function automatic logic [5:0] pick_stored_index();
    logic [5:0] i;
    i = 6'($urandom);
    while (!stored[i]) i = i + 6'd1;
    return i;
  endfunction

  function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s expected %0h got %0h", name, want_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (status_due.size() == 0) begin
          $error("result with nothing pending: %h", m_tdata);
          fails++;
        end else begin
          got_want = status_due.pop_front();
          check_field("frame_ready", got_want.frame_ready, m_tdata[0]);
          check_field("frame_accepted", got_want.frame_accepted, m_tdata[1]);
          check_field("crc_mismatch", got_want.crc_mismatch, m_tdata[2]);
          check_field("framing_error", got_want.framing_error, m_tdata[3]);
          check_field("held_id", got_want.held_id, m_tdata[11:4]);
          check_field("held_length", got_want.held_length, m_tdata[18:12]);
          check_field("read_data", got_want.read_data, m_tdata[26:19]);
        end
      end
      m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  task automatic send_item(action_t act, logic [7:0] b, logic [5:0] idx,
                           bit typed = 1'b0, rx_status_t want = '0);
    rx_status_t predicted;
    bit ignored;
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, idx, b};
    s_tuser <= act;
    do @(posedge clk); while (!s_tready);
    ignored = (act == ACT_RX) && held;
    predicted = deframe_step(act, b, idx);
    status_due.push_back(typed ? want : predicted);
    if (!ignored) items_done++;
  endtask

  task automatic add_row(action_t act, logic [7:0] d, logic [5:0] idx, byte_src_t src,
                         bit typed, rx_status_t want);
    stim_row_t r;
    r.act = act;
    r.data = d;
    r.idx = idx;
    r.src = src;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endtask

  task automatic cfg_write(reg_index_t a, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_config(sfr_cfg_t c);
    cfg_write(REG_HEADER_FIRST, {8'h00, c.header_first});
    cfg_write(REG_HEADER_SECOND, {8'h00, c.header_second});
    cfg_write(REG_TRAILER_FIRST, {8'h00, c.trailer_first});
    cfg_write(REG_TRAILER_SECOND, {8'h00, c.trailer_second});
    cfg_write(REG_CHECK_ENABLE, {15'd0, c.check_enable});
    cfg_write(REG_CRC_POLYNOMIAL, c.crc_polynomial);
    cfg_write(REG_CRC_START, c.crc_start);
    cfg_we <= 1'b0;
    cfg = c;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic send_noise();
    action_t a;
    a = action_t'($urandom_range(3));
    if (a == ACT_READ && !any_stored) a = ACT_UNDEFINED;
    send_item(a, 8'($urandom), (a == ACT_READ) ? pick_stored_index() : 6'($urandom));
  endtask

  task automatic send_frame();
    logic [7:0] len;
    logic [7:0] b;
    logic [15:0] crc;
    int r;
    r = $urandom_range(99);
    if (r < 6) len = 8'd0;
    else if (r < 62) len = 8'($urandom_range(1, 8));
    else if (r < 80) len = 8'($urandom_range(9, 63));
    else if (r < 88) len = 8'd64;
    else len = 8'($urandom_range(65, 255));
    send_item(ACT_RX, cfg.header_first, 6'($urandom));
    if ($urandom_range(19) == 0) begin
      send_item(ACT_RX, cfg.header_second ^ 8'($urandom_range(1, 255)), 6'($urandom));
      return;
    end
    send_item(ACT_RX, cfg.header_second, 6'($urandom));
    send_item(ACT_RX, 8'($urandom), 6'($urandom));
    send_item(ACT_RX, len, 6'($urandom));
    if (len > PAYLOAD_CAP) return;
    crc = cfg.crc_start;
    repeat (len) begin
      b = 8'($urandom);
      crc = crc16_update(crc, b);
      send_item(ACT_RX, b, 6'($urandom));
    end
    if ($urandom_range(9) == 0) crc = crc ^ 16'($urandom_range(1, 65535));
    send_item(ACT_RX, crc[7:0], 6'($urandom));
    send_item(ACT_RX, crc[15:8], 6'($urandom));
    b = cfg.trailer_first;
    if ($urandom_range(15) == 0) b = b ^ 8'($urandom_range(1, 255));
    send_item(ACT_RX, b, 6'($urandom));
    b = cfg.trailer_second;
    if ($urandom_range(15) == 0) b = b ^ 8'($urandom_range(1, 255));
    send_item(ACT_RX, b, 6'($urandom));
  endtask

  function automatic sfr_cfg_t cfg_for_phase(int ph);
    sfr_cfg_t c;
    case (ph)
      0: c = '{8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1, 16'hFFFF, 16'h0000};
      1: c = '{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, 16'h0000, 16'hFFFF};
      default: c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1,
                     16'($urandom), 16'($urandom)};
    endcase
    return c;
  endfunction

  initial begin
    logic [7:0] d;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACT_RX;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_HEADER_FIRST;
    cfg_wdata = '0;
    fails = 0;
    cycles = 0;
    items_done = 0;
    cfg = '{HEADER_FIRST_RST, HEADER_SECOND_RST, TRAILER_FIRST_RST, TRAILER_SECOND_RST,
            CHECK_ENABLE_RST, CRC_POLYNOMIAL_RST, CRC_START_RST};
    phase = P_HEAD1;
    for (int i = 0; i < PAYLOAD_CAP; i++) begin
      payload[i] = 8'h00;
      stored[i] = 1'b0;
    end
    any_stored = 1'b0;
    wr_pos = '0;
    hold_ident = '0;
    frame_len = '0;
    crc_rx = '0;
    crc_acc = CRC_START_RST;
    held = 1'b0;
    send_gap_pct = 26;
    ready_stall_pct = 67;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_row(ACT_UNDEFINED, 8'hFF, 6'h3F, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RELEASE, 8'h00, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    // a bad second header sends the byte back without a second look
    add_row(ACT_RX, 8'hAA, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'hAA, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h55, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    // length over capacity
    add_row(ACT_RX, 8'hAA, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h55, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h00, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'hFF, 6'h00, BYTE_LIT, 1'b1, ST_FRAMING);
    // two-byte payload with a corrupted CRC high byte
    add_row(ACT_RX, 8'hAA, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h55, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h00, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h02, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h00, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'hFF, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h00, 6'h00, BYTE_CRC_LO, 1'b0, ST_IDLE);
    add_row(ACT_RX, 8'h00, 6'h00, BYTE_CRC_HI_BAD, 1'b0, ST_IDLE);
    add_row(ACT_RX, 8'h0D, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h0A, 6'h00, BYTE_LIT, 1'b1, ST_CRC_BAD);
    // empty payload: CRC equals the start value
    add_row(ACT_RX, 8'hAA, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h55, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'hFF, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h00, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'hFF, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'hFF, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h0D, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);
    add_row(ACT_RX, 8'h0A, 6'h00, BYTE_LIT, 1'b1, ST_ACCEPTED);
    // reads past the held length return earlier payload
    add_row(ACT_READ, 8'h00, 6'h00, BYTE_LIT, 1'b1, ST_HELD);
    add_row(ACT_READ, 8'h00, 6'h01, BYTE_LIT, 1'b1, ST_HELD_FF);
    add_row(ACT_RX, 8'h3C, 6'h00, BYTE_LIT, 1'b1, ST_HELD);
    add_row(ACT_RELEASE, 8'h00, 6'h00, BYTE_LIT, 1'b1, ST_IDLE);

    foreach (plan[i]) begin
      case (plan[i].src)
        BYTE_CRC_LO: d = crc_acc[7:0];
        BYTE_CRC_HI_BAD: d = ~crc_acc[15:8];
        default: d = plan[i].data;
      endcase
      send_item(plan[i].act, d, plan[i].idx, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      settle();
      load_config(cfg_for_phase(ph));
      send_gap_pct = (ph == 0) ? 26 : (ph == 1) ? 67 : 0;
      ready_stall_pct = (ph == 0) ? 67 : (ph == 1) ? 26 : 0;
      while (items_done < 30 + (ph + 1) * 430) begin
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) send_noise();
        send_frame();
        if (held) begin
          if ($urandom_range(1) == 1) begin
            repeat ($urandom_range(1, 3)) send_item(ACT_RX, 8'($urandom), 6'($urandom));
          end
          if (any_stored) begin
            repeat ($urandom_range(1, 4)) begin
              send_item(ACT_READ, 8'($urandom),
                        (frame_len != 0 && $urandom_range(9) < 7) ?
                        6'($urandom_range(0, frame_len - 1)) : pick_stored_index());
            end
          end
          if ($urandom_range(9) != 0) send_item(ACT_RELEASE, 8'($urandom), 6'($urandom));
        end
      end
    end

    settle();
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
